FILE: sv/thermal_window_alarm_monitor_macros.svh
// Assertion helpers used by the checker file.
// All checks sample on clk and are masked while rst_n is low.
`ifndef THERMAL_WINDOW_ALARM_MONITOR_MACROS_SVH
`define THERMAL_WINDOW_ALARM_MONITOR_MACROS_SVH

// Plain property check.
`define TWAM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("twam check failed");

// Antecedent in one cycle, consequent in the next.
`define TWAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twam check failed");

`endif

FILE: sv/twam_pkg.sv
// ----------------------------------------------------------------------------
// twam_pkg
// Shared constants, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package twam_pkg;

    localparam int WINDOW_LEN_DEF  = 65;
    localparam int GROUP_LEN_DEF   = 5;
    localparam int GROUP_COUNT_DEF = 13;
    localparam int CHANNELS        = 8;
    localparam int BOARD_CH        = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int PEER_SUM_W      = 10;

    localparam logic [7:0] WARN_ABS_RST   = 8'd160;
    localparam logic [7:0] ALARM_ABS_RST  = 8'd180;
    localparam logic [7:0] WARN_DIFF_RST  = 8'd50;
    localparam logic [7:0] ALARM_DIFF_RST = 8'd65;
    localparam logic [7:0] RISE_RST       = 8'd15;
    localparam logic [7:0] RISE_ABS_RST   = 8'd130;
    localparam logic [7:0] FAULT_RST      = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARN_ABS   = 3'd0,
        REG_ALARM_ABS  = 3'd1,
        REG_WARN_DIFF  = 3'd2,
        REG_ALARM_DIFF = 3'd3,
        REG_RISE       = 3'd4,
        REG_RISE_ABS   = 3'd5,
        REG_FAULT      = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DSEL_G1   = 2'd0,
        DSEL_GL2  = 2'd1,
        DSEL_GL1  = 2'd2,
        DSEL_PEER = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     write;
        logic     update;
        logic     eval_init;
        logic     walk_start;
        logic     walk_step;
        logic     cur_read;
        logic     div_start;
        div_sel_t div_sel;
        logic     store_div;
        logic     store_ch;
        logic     next_ch;
        logic     peer_start;
        logic     decide;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic k_last;
        logic both_full;
        logic walk_last;
        logic div_done;
        logic ch_last;
        logic peer_none;
        logic out_free;
    } stat_t;

endpackage

FILE: sv/thermal_window_alarm_monitor.sv
// ----------------------------------------------------------------------------
// thermal_window_alarm_monitor
// Eight-channel sliding-window temperature monitor with warn/alarm masks.
// ----------------------------------------------------------------------------
// Each input word carries one board's four samples (tuser selects the board)
// and its samples are stored one at a time, as the window memory has a single
// write port. When both boards have sent their new sample the block evaluates
// all eight channels: per channel it walks GROUP_COUNT*GROUP_LEN window entries
// through the single memory read port and forms the group averages by
// reciprocal multiply; a peer pass follows with one 11-step serial division
// per channel that has unflagged peers. No input word is taken during an
// evaluation. The result waits in an output register; the window memory
// needs no clearing after reset.
module thermal_window_alarm_monitor #(
    parameter int WINDOW_LEN  = twam_pkg::WINDOW_LEN_DEF,
    parameter int GROUP_LEN   = twam_pkg::GROUP_LEN_DEF,
    parameter int GROUP_COUNT = twam_pkg::GROUP_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // temp_a, temp_b, temp_c, temp_d
    input  logic                           s_tuser,   // board_side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // warn_mask, alarm_mask
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [twam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    twam_pkg::cmd_t  cmd;
    twam_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    twam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    twam_dp #(
        .WINDOW_LEN  (WINDOW_LEN),
        .GROUP_LEN   (GROUP_LEN),
        .GROUP_COUNT (GROUP_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_side   (s_tuser),
        .in_temps  (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: sv/twam_div.sv
// ----------------------------------------------------------------------------
// twam_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twam_div #(
    parameter int DIV_W = 11,
    parameter int DVS_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;

    logic [DVS_W:0]   shifted;
    logic             ge;
    logic [DVS_W:0]   diff_val;

    always_comb
    begin
        shifted  = {rem_reg, q_reg[DIV_W-1]};
        ge       = shifted >= {1'b0, divisor};
        diff_val = shifted - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff_val[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: sv/twam_ctrl.sv
// ----------------------------------------------------------------------------
// twam_ctrl
// Sequencer: sample store, per-channel window walk, peer compare, result.
// ----------------------------------------------------------------------------
module twam_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  twam_pkg::stat_t  stat,
    output twam_pkg::cmd_t   cmd
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_WRITE  = 15'b000000000000010,
        S_UPDATE = 15'b000000000000100,
        S_CHECK  = 15'b000000000001000,
        S_WSTART = 15'b000000000010000,
        S_WALK   = 15'b000000000100000,
        S_CUR    = 15'b000000001000000,
        S_DRAIN  = 15'b000000010000000,
        S_DIV1   = 15'b000000100000000,
        S_DIV2   = 15'b000001000000000,
        S_DIV3   = 15'b000010000000000,
        S_PEER   = 15'b000100000000000,
        S_PDIV   = 15'b001000000000000,
        S_DECIDE = 15'b010000000000000,
        S_FINISH = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = twam_pkg::DSEL_G1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                if (stat.k_last)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.both_full)
                begin
                    cmd.eval_init = 1'b1;
                    state_next    = S_WSTART;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WSTART:
            begin
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                    state_next = S_CUR;
            end
            S_CUR:
            begin
                cmd.cur_read = 1'b1;
                state_next   = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DIV1;
            end
            // group averages come from the reciprocal multiply, one per cycle
            S_DIV1:
            begin
                cmd.store_div = 1'b1;
                cmd.div_sel   = twam_pkg::DSEL_G1;
                state_next    = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_sel   = twam_pkg::DSEL_GL2;
                cmd.store_div = 1'b1;
                state_next    = S_DIV3;
            end
            S_DIV3:
            begin
                cmd.div_sel  = twam_pkg::DSEL_GL1;
                cmd.store_ch = 1'b1;
                cmd.next_ch  = 1'b1;
                state_next   = stat.ch_last ? S_PEER : S_WSTART;
            end
            S_PEER:
            begin
                cmd.peer_start = 1'b1;
                cmd.div_sel    = twam_pkg::DSEL_PEER;
                if (stat.peer_none)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_PDIV;
                end
            end
            S_PDIV:
            begin
                cmd.div_sel = twam_pkg::DSEL_PEER;
                if (stat.div_done)
                begin
                    cmd.store_div = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide  = 1'b1;
                cmd.next_ch = 1'b1;
                state_next  = stat.ch_last ? S_FINISH : S_PEER;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/twam_dp.sv
// ----------------------------------------------------------------------------
// twam_dp
// Datapath: window memory, fill/head tracking, group sums, divider,
// peer compare and threshold checks, config registers and output register.
// ----------------------------------------------------------------------------
module twam_dp #(
    parameter int WINDOW_LEN  = twam_pkg::WINDOW_LEN_DEF,
    parameter int GROUP_LEN   = twam_pkg::GROUP_LEN_DEF,
    parameter int GROUP_COUNT = twam_pkg::GROUP_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_side,
    input  logic [31:0]                    in_temps,
    input  logic                           cfg_we,
    input  logic [twam_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [15:0]                    out_data,
    input  twam_pkg::cmd_t                 cmd,
    output twam_pkg::stat_t                stat
);

    localparam int CH     = twam_pkg::CHANNELS;
    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 2);
    localparam int ADDR_W = $clog2(CH * WINDOW_LEN);
    localparam int SUM_W  = 8 + $clog2(GROUP_LEN + 1);
    localparam int T_W    = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;
    localparam int G_W    = $clog2(GROUP_COUNT);
    localparam int PS_W   = twam_pkg::PEER_SUM_W;
    localparam int DIV_W  = (SUM_W > PS_W) ? SUM_W : PS_W;
    localparam int DVS_W  = ($clog2(GROUP_LEN + 1) > 2) ? $clog2(GROUP_LEN + 1) : 2;
    // x / GROUP_LEN == (x * RCP_M) >> RCP_S for every x below 2^SUM_W
    localparam int RCP_S  = SUM_W + 4;
    localparam int RCP_W  = RCP_S + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_M = RCP_W'(((1 << RCP_S) + GROUP_LEN - 1) / GROUP_LEN);

    // config registers
    logic [7:0] warn_abs_reg, alarm_abs_reg, warn_diff_reg, alarm_diff_reg;
    logic [7:0] rise_lvl_reg, rise_abs_reg, fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_abs_reg   <= twam_pkg::WARN_ABS_RST;
            alarm_abs_reg  <= twam_pkg::ALARM_ABS_RST;
            warn_diff_reg  <= twam_pkg::WARN_DIFF_RST;
            alarm_diff_reg <= twam_pkg::ALARM_DIFF_RST;
            rise_lvl_reg   <= twam_pkg::RISE_RST;
            rise_abs_reg   <= twam_pkg::RISE_ABS_RST;
            fault_reg      <= twam_pkg::FAULT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                twam_pkg::REG_WARN_ABS:   warn_abs_reg   <= cfg_wdata;
                twam_pkg::REG_ALARM_ABS:  alarm_abs_reg  <= cfg_wdata;
                twam_pkg::REG_WARN_DIFF:  warn_diff_reg  <= cfg_wdata;
                twam_pkg::REG_ALARM_DIFF: alarm_diff_reg <= cfg_wdata;
                twam_pkg::REG_RISE:       rise_lvl_reg   <= cfg_wdata;
                twam_pkg::REG_RISE_ABS:   rise_abs_reg   <= cfg_wdata;
                twam_pkg::REG_FAULT:      fault_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
        idx_inc = (x == IDX_W'(WINDOW_LEN - 1)) ? '0 : x + 1'b1;
    endfunction

    // captured word
    logic       side_reg;
    logic [7:0] temp_reg [4];
    logic [1:0] k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            side_reg    <= in_side;
            temp_reg[0] <= in_temps[7:0];
            temp_reg[1] <= in_temps[15:8];
            temp_reg[2] <= in_temps[23:16];
            temp_reg[3] <= in_temps[31:24];
        end
    end

    // fill and head per board
    logic [FILL_W-1:0] fill0_reg, fill1_reg;
    logic [IDX_W-1:0]  head0_reg, head1_reg;
    logic [FILL_W-1:0] fill_sel;
    logic [IDX_W-1:0]  head_sel;

    assign fill_sel = side_reg ? fill1_reg : fill0_reg;
    assign head_sel = side_reg ? head1_reg : head0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            fill0_reg <= '0;
            fill1_reg <= '0;
            head0_reg <= '0;
            head1_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
                k_reg <= '0;
            else if (cmd.write)
                k_reg <= k_reg + 1'b1;
            if (cmd.update && fill_sel <= FILL_W'(WINDOW_LEN))
            begin
                if (side_reg)
                begin
                    fill1_reg <= fill1_reg + 1'b1;
                    if (fill1_reg == FILL_W'(WINDOW_LEN))
                        head1_reg <= idx_inc(head1_reg);
                end
                else
                begin
                    fill0_reg <= fill0_reg + 1'b1;
                    if (fill0_reg == FILL_W'(WINDOW_LEN))
                        head0_reg <= idx_inc(head0_reg);
                end
            end
            if (cmd.eval_init)
            begin
                fill0_reg <= FILL_W'(WINDOW_LEN);
                fill1_reg <= FILL_W'(WINDOW_LEN);
            end
        end
    end

    // window memory
    logic [7:0]        mem [CH * WINDOW_LEN];
    logic [7:0]        rdata_reg;
    logic [2:0]        ch_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  head_ch;
    logic [IDX_W-1:0]  cur_idx;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    assign wr_idx  = (fill_sel < FILL_W'(WINDOW_LEN)) ? fill_sel[IDX_W-1:0] : head_sel;
    assign wr_en   = cmd.write && (fill_sel <= FILL_W'(WINDOW_LEN));
    assign wr_addr = ADDR_W'({side_reg, k_reg}) * ADDR_W'(WINDOW_LEN) + ADDR_W'(wr_idx);
    assign head_ch = ch_reg[2] ? head1_reg : head0_reg;
    assign cur_idx = (head_ch == '0) ? IDX_W'(WINDOW_LEN - 1) : head_ch - 1'b1;
    assign rd_addr = ADDR_W'(ch_reg) * ADDR_W'(WINDOW_LEN)
                   + ADDR_W'(cmd.cur_read ? cur_idx : idx_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= temp_reg[k_reg];
        if (cmd.walk_step || cmd.cur_read)
            rdata_reg <= mem[rd_addr];
    end

    // window walk
    logic [T_W-1:0]   t_reg;
    logic [G_W-1:0]   g_reg;
    logic             rv_reg, rcur_reg;
    logic [2:0]       rhit_reg;
    logic [SUM_W-1:0] s1_reg, s2_reg, s3_reg;
    logic [7:0]       curv_reg;
    logic             t_last;

    assign t_last = (t_reg == T_W'(GROUP_LEN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg   <= 1'b0;
            rcur_reg <= 1'b0;
            ch_reg   <= '0;
        end
        else
        begin
            rv_reg   <= cmd.walk_step;
            rcur_reg <= cmd.cur_read;
            if (cmd.eval_init)
                ch_reg <= '0;
            else if (cmd.next_ch)
                ch_reg <= ch_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            idx_reg <= head_ch;
            t_reg   <= '0;
            g_reg   <= '0;
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
        end
        else
        begin
            if (cmd.walk_step)
            begin
                idx_reg  <= idx_inc(idx_reg);
                rhit_reg <= {g_reg == G_W'(GROUP_COUNT - 1), g_reg == G_W'(GROUP_COUNT - 2),
                             g_reg == G_W'(1)};
                if (t_last)
                begin
                    t_reg <= '0;
                    g_reg <= g_reg + 1'b1;
                end
                else
                begin
                    t_reg <= t_reg + 1'b1;
                end
            end
            if (rv_reg)
            begin
                if (rhit_reg[0])
                    s1_reg <= s1_reg + SUM_W'(rdata_reg);
                if (rhit_reg[1])
                    s2_reg <= s2_reg + SUM_W'(rdata_reg);
                if (rhit_reg[2])
                    s3_reg <= s3_reg + SUM_W'(rdata_reg);
            end
        end
        if (rcur_reg)
            curv_reg <= rdata_reg;
    end

    // peer sum over the same board
    logic [7:0]      avgl2_arr [CH];
    logic [7:0]      rise_arr  [CH];
    logic [7:0]      cur_arr   [CH];
    logic [7:0]      flagged;
    logic [PS_W-1:0] psum;
    logic [1:0]      pcnt;
    logic [7:0]      avg_self;

    always_comb
    begin
        psum     = '0;
        pcnt     = '0;
        avg_self = '0;
        for (int p = 0; p < CH; p++)
        begin
            if (3'(p) == ch_reg)
                avg_self = avgl2_arr[p];
            else if (3'(p >> 2) == {2'b00, ch_reg[2]} && !flagged[p])
            begin
                psum = psum + PS_W'(avgl2_arr[p]);
                pcnt = pcnt + 1'b1;
            end
        end
    end

    // serial divider, peer mean only
    logic [DIV_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
    logic             div_done;
    logic [DIV_W-1:0] quot;
    logic [7:0]       q8;

    assign dvd = DIV_W'(psum);
    assign dvs = DVS_W'(pcnt);

    twam_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quot)
    );

    // group averages by reciprocal multiply
    logic [SUM_W-1:0]  gsum;
    logic [PROD_W-1:0] gprod;
    logic [7:0]        gavg;

    always_comb
    begin
        case (cmd.div_sel)
            twam_pkg::DSEL_G1:  gsum = s1_reg;
            twam_pkg::DSEL_GL2: gsum = s2_reg;
            default:            gsum = s3_reg;
        endcase
    end

    assign gprod = PROD_W'(gsum) * PROD_W'(RCP_M);
    assign gavg  = gprod[RCP_S +: 8];
    assign q8    = (cmd.div_sel == twam_pkg::DSEL_PEER) ? quot[7:0] : gavg;

    logic [7:0] a1_reg, a2_reg, diff_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store_div)
        begin
            case (cmd.div_sel)
                twam_pkg::DSEL_G1:   a1_reg   <= q8;
                twam_pkg::DSEL_GL2:  a2_reg   <= q8;
                twam_pkg::DSEL_PEER: diff_reg <= (avg_self >= q8) ? avg_self - q8
                                                                  : q8 - avg_self;
                default: ;
            endcase
        end
        if (cmd.peer_start)
            diff_reg <= '0;
        if (cmd.store_ch)
        begin
            avgl2_arr[ch_reg] <= a2_reg;
            rise_arr[ch_reg]  <= (q8 >= a1_reg) ? q8 - a1_reg : a1_reg - q8;
            cur_arr[ch_reg]   <= curv_reg;
        end
    end

    // threshold checks and result
    logic [7:0] warn_state_reg, alarm_state_reg;
    logic [7:0] wm_reg, am_reg;
    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic [7:0] cur_ch;
    logic       w_bit, a_bit;

    assign flagged = warn_state_reg | alarm_state_reg;
    assign cur_ch  = cur_arr[ch_reg];

    always_comb
    begin
        w_bit = (cur_ch >= warn_abs_reg)
             || (diff_reg >= warn_diff_reg && diff_reg < alarm_diff_reg);
        a_bit = (diff_reg >= alarm_diff_reg) || (cur_ch >= alarm_abs_reg)
             || (rise_arr[ch_reg] >= rise_lvl_reg && cur_ch >= rise_abs_reg)
             || (cur_ch == fault_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_state_reg  <= '0;
            alarm_state_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                warn_state_reg  <= wm_reg;
                alarm_state_reg <= am_reg;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_init)
        begin
            wm_reg <= '0;
            am_reg <= '0;
        end
        else if (cmd.decide)
        begin
            wm_reg[ch_reg] <= w_bit;
            am_reg[ch_reg] <= a_bit;
        end
        if (cmd.finish)
            out_data_reg <= {am_reg, wm_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        stat.k_last    = (k_reg == 2'd3);
        stat.both_full = (fill0_reg == FILL_W'(WINDOW_LEN + 1))
                      && (fill1_reg == FILL_W'(WINDOW_LEN + 1));
        stat.walk_last = t_last && (g_reg == G_W'(GROUP_COUNT - 1));
        stat.div_done  = div_done;
        stat.ch_last   = (ch_reg == 3'd7);
        stat.peer_none = (pcnt == '0);
        stat.out_free  = !out_valid_reg || out_ready;
    end

endmodule

FILE: sv/twam_checker.sv
// ----------------------------------------------------------------------------
// twam_checker
// Port-level checks for the monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "thermal_window_alarm_monitor_macros.svh"

module twam_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a result held back keeps its word
    `TWAM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // storing a word blocks the input for at least the next cycle
    `TWAM_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)
    // a fresh result only appears at the end of an evaluation, never from idle
    `TWAM_ASSERT(a_out_from_eval, $rose(m_tvalid) |-> !$past(s_tready))

endmodule

bind thermal_window_alarm_monitor twam_checker u_twam_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: thermal window alarm monitor testbench
// Streams board sample words into the monitor and checks every mask word
// against a cycle-free model of the windows, averages and thresholds kept
// here, under random idling, a long output hold-off and several threshold
// settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WLEN  = twam_pkg::WINDOW_LEN_DEF;
    localparam int GLEN  = twam_pkg::GROUP_LEN_DEF;
    localparam int GCNT  = twam_pkg::GROUP_COUNT_DEF;
    localparam int IDLE_LIMIT = 30000;
    localparam logic [twam_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // temp_a, temp_b, temp_c, temp_d
    logic        s_tuser;   // board_side
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // warn_mask, alarm_mask
    logic        cfg_valid;
    logic        cfg_ready;
    logic [twam_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]  cfg_data;

    thermal_window_alarm_monitor dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    logic [7:0]  win [twam_pkg::CHANNELS][WLEN];
    int          head [2];
    int          fill [2];
    logic [7:0]  warn_st, alarm_st;
    logic [7:0]  level [7];
    logic [15:0] expected_masks [$];

    int  errors;
    bit  quiet;
    int  hold_req;
    int  hold_left;
    int  stall_left;
    int  idle_cycles;
    int  drift [2];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int group_avg(int ch, int oldest, int g);
        int sum;
        sum = 0;
        for (int t = 0; t < GLEN; t++)
            sum += win[ch][(oldest + g * GLEN + t) % WLEN];
        return sum / GLEN;
    endfunction

    function automatic int abs_delta(int a, int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic void predict_masks(bit side, logic [31:0] word);
        int base, oldest, first, sum, cnt, diff;
        int late [twam_pkg::CHANNELS];
        int rise [twam_pkg::CHANNELS];
        int cur [twam_pkg::CHANNELS];
        logic [7:0] flagged, wm, am;
        bit w, a;
        base = side * 4;
        if (fill[side] < WLEN)
        begin
            for (int k = 0; k < 4; k++)
                win[base + k][fill[side]] = word[8*k +: 8];
            fill[side]++;
        end
        else if (fill[side] == WLEN)
        begin
            for (int k = 0; k < 4; k++)
                win[base + k][head[side]] = word[8*k +: 8];
            head[side] = (head[side] + 1) % WLEN;
            fill[side]++;
        end
        if (fill[0] != WLEN + 1 || fill[1] != WLEN + 1)
            return;
        fill[0] = WLEN;
        fill[1] = WLEN;
        for (int ch = 0; ch < twam_pkg::CHANNELS; ch++)
        begin
            oldest   = head[ch >> 2];
            late[ch] = group_avg(ch, oldest, GCNT - 2);
            rise[ch] = abs_delta(group_avg(ch, oldest, GCNT - 1), group_avg(ch, oldest, 1));
            cur[ch]  = win[ch][(oldest + WLEN - 1) % WLEN];
        end
        flagged = warn_st | alarm_st;
        wm = '0;
        am = '0;
        for (int ch = 0; ch < twam_pkg::CHANNELS; ch++)
        begin
            first = ch & 4;
            sum = 0;
            cnt = 0;
            diff = 0;
            for (int p = first; p < first + 4; p++)
            begin
                if (p == ch || flagged[p])
                    continue;
                sum += late[p];
                cnt++;
            end
            if (cnt != 0)
                diff = abs_delta(late[ch], sum / cnt);
            w = cur[ch] >= level[twam_pkg::REG_WARN_ABS] ||
                (diff >= level[twam_pkg::REG_WARN_DIFF] &&
                 diff < level[twam_pkg::REG_ALARM_DIFF]);
            a = diff >= level[twam_pkg::REG_ALARM_DIFF] ||
                cur[ch] >= level[twam_pkg::REG_ALARM_ABS] ||
                (rise[ch] >= level[twam_pkg::REG_RISE] &&
                 cur[ch] >= level[twam_pkg::REG_RISE_ABS]) ||
                cur[ch] == level[twam_pkg::REG_FAULT];
            wm[ch] = w;
            am[ch] = a;
        end
        warn_st  = wm;
        alarm_st = am;
        expected_masks.push_back({am, wm});
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_masks.size() == 0)
            begin
                report_mismatch("unexpected mask word", int'(m_tdata), 0);
            end
            else
            begin
                want = expected_masks.pop_front();
                if (m_tdata[7:0] !== want[7:0])
                    report_mismatch("warn_mask", m_tdata[7:0], want[7:0]);
                if (m_tdata[15:8] !== want[15:8])
                    report_mismatch("alarm_mask", m_tdata[15:8], want[15:8]);
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                      (cfg_valid && cfg_ready)))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(bit side, logic [31:0] word);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= side;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        predict_masks(side, word);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // wait for every mask word, then let any storing word finish
    task automatic wait_idle();
        stop_sending();
        wait (expected_masks.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [twam_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx < 7)
            level[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_levels(logic [7:0] wa, logic [7:0] aa, logic [7:0] wd,
                                logic [7:0] ad, logic [7:0] r, logic [7:0] ra,
                                logic [7:0] f);
        write_reg(twam_pkg::REG_WARN_ABS, wa);
        write_reg(twam_pkg::REG_ALARM_ABS, aa);
        write_reg(twam_pkg::REG_WARN_DIFF, wd);
        write_reg(twam_pkg::REG_ALARM_DIFF, ad);
        write_reg(twam_pkg::REG_RISE, r);
        write_reg(twam_pkg::REG_RISE_ABS, ra);
        write_reg(twam_pkg::REG_FAULT, f);
    endtask

    function automatic logic [31:0] four(logic [7:0] v);
        return {v, v, v, v};
    endfunction

    // samples near a slowly moving board level, with the odd spike
    function automatic logic [31:0] drift_word(bit side);
        logic [31:0] word;
        int v;
        drift[side] = drift[side] + $urandom_range(0, 8) - 4;
        if (drift[side] < 0) drift[side] = 0;
        if (drift[side] > 255) drift[side] = 255;
        for (int k = 0; k < 4; k++)
        begin
            v = drift[side] + $urandom_range(0, 10) - 5;
            if ($urandom_range(0, 30) == 0)
                v = v + $urandom_range(0, 160) - 80;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            word[8*k +: 8] = 8'(v);
        end
        return word;
    endfunction

    function automatic logic [31:0] random_word(bit side);
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        return drift_word(side);
    endfunction

    task automatic test_fill();
        for (int n = 0; n < WLEN; n++)
        begin
            send_word(1'b0, drift_word(1'b0));
            send_word(1'b1, drift_word(1'b1));
        end
    endtask

    task automatic test_directed();
        send_word(1'b0, four(8'h00));
        send_word(1'b1, four(8'hff));
        // second word for a board still waiting on the other is dropped
        send_word(1'b0, four(8'h20));
        send_word(1'b0, four(8'hff));
        send_word(1'b1, four(8'h00));
        send_word(1'b1, {8'd160, 8'd159, 8'd180, 8'd179});
        send_word(1'b0, {8'd130, 8'd129, 8'd181, 8'd254});
        send_word(1'b0, 32'haa55_aa55);
        send_word(1'b1, 32'h55aa_55aa);
        send_word(1'b1, 32'h0102_0408);
        send_word(1'b0, 32'h1020_4080);
        wait_idle();
        write_reg(twam_pkg::REG_FAULT, 8'h00);
        write_reg(REG_UNUSED, 8'h5a);
        send_word(1'b0, {8'h00, 8'h10, 8'h00, 8'h7f});
        send_word(1'b1, {8'h80, 8'h00, 8'h01, 8'h00});
        wait_idle();
    endtask

    task automatic run_stream(int items);
        bit side;
        for (int n = 0; n < items; n += 2)
        begin
            side = $urandom_range(0, 1);
            send_word(side, random_word(side));
            if ($urandom_range(0, 9) == 0)
                send_word(side, random_word(side));
            send_word(!side, random_word(!side));
        end
        wait_idle();
    endtask

    task automatic test_level_extremes();
        write_levels(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_stream(60);
        write_levels(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        run_stream(60);
        write_levels(8'd160, 8'd180, 8'd50, 8'd65, 8'd15, 8'd130, 8'd255);
        run_stream(120);
    endtask

    task automatic test_random_levels();
        logic [7:0] wd;
        for (int phase = 0; phase < 4; phase++)
        begin
            wd = 8'($urandom_range(0, 60));
            write_levels(8'($urandom_range(100, 255)), 8'($urandom_range(120, 255)), wd,
                         8'(wd + $urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                         8'($urandom_range(60, 200)), 8'($urandom));
            write_reg(REG_UNUSED, 8'($urandom));
            run_stream(120);
        end
    endtask

    task automatic test_output_holdoff();
        @(posedge clk);
        hold_req = 6000;
        for (int n = 0; n < 12; n++)
        begin
            send_word(1'b0, random_word(1'b0));
            send_word(1'b1, random_word(1'b1));
        end
        wait_idle();
    endtask

    task automatic test_steady_flow();
        quiet = 1'b1;
        write_levels(8'd150, 8'd200, 8'd20, 8'd40, 8'd8, 8'd100, 8'd254);
        run_stream(100);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        clk = 1'b0;
        errors = 0;
        quiet = 1'b0;
        hold_req = 0;
        hold_left = 0;
        stall_left = 0;
        idle_cycles = 0;
        head = '{0, 0};
        fill = '{0, 0};
        drift = '{90, 110};
        warn_st = '0;
        alarm_st = '0;
        level[twam_pkg::REG_WARN_ABS]   = twam_pkg::WARN_ABS_RST;
        level[twam_pkg::REG_ALARM_ABS]  = twam_pkg::ALARM_ABS_RST;
        level[twam_pkg::REG_WARN_DIFF]  = twam_pkg::WARN_DIFF_RST;
        level[twam_pkg::REG_ALARM_DIFF] = twam_pkg::ALARM_DIFF_RST;
        level[twam_pkg::REG_RISE]       = twam_pkg::RISE_RST;
        level[twam_pkg::REG_RISE_ABS]   = twam_pkg::RISE_ABS_RST;
        level[twam_pkg::REG_FAULT]      = twam_pkg::FAULT_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fill();
        test_directed();
        test_level_extremes();
        test_random_levels();
        test_output_holdoff();
        test_steady_flow();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/twam_pkg.sv
sv/twam_div.sv
sv/twam_ctrl.sv
sv/twam_dp.sv
sv/thermal_window_alarm_monitor.sv
sv/twam_checker.sv
test/tb_top.sv
